@@ rtl/assert_macros.svh @@
// Assertion macros shared by the periodic timer set RTL.
// Checks compile only when SYNTHESIS is not defined; otherwise they vanish.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante must be followed by cons in the same cycle
`define PTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// cond must never hold
`define PTS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define PTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PTS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/ptset_pkg.sv @@
// Shared types, codes and helpers for the periodic timer set.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ptset_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int SLOT_CAP       = 16;
  localparam int TW             = 48;
  localparam int PW             = 32;
  localparam int QDEPTH         = 2;

  localparam logic [TW-1:0] TIME_MAX = '1;

  // request modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [3:0]    id;
    logic          in_range;
    logic [PW-1:0] period;
    logic [TW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t, input logic [PW-1:0] p);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW-PW+1){1'b0}}, p};
    return s[TW] ? TIME_MAX : s[TW-1:0];
  endfunction

endpackage

@@ rtl/ptset_front.sv @@
// Front end: takes requests, drops the unused mode, tags slot range.
// Depends on ptset_pkg; feeds ptset_cmd_fifo.
`timescale 1ns / 1ps

module ptset_front #(
  parameter int NUM_TIMERS = ptset_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [3:0]                 in_timer_id,
  input  logic [ptset_pkg::PW-1:0]   in_period,
  input  logic [ptset_pkg::TW-1:0]   in_now_time,
  output logic                       push,
  output ptset_pkg::cmd_t            push_cmd,
  input  ptset_pkg::qstat_t          q_stat
);

  localparam int SLOTS = (NUM_TIMERS < ptset_pkg::SLOT_CAP) ? NUM_TIMERS : ptset_pkg::SLOT_CAP;

  logic            vld_r, vld_nxt;
  ptset_pkg::cmd_t cmd_r;
  logic            accept, keep;

  assign in_stall = vld_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = vld_r && !q_stat.full;
  assign push_cmd = cmd_r;

  always_comb begin
    unique case (in_mode)
      ptset_pkg::MODE_ADD,
      ptset_pkg::MODE_REMOVE,
      ptset_pkg::MODE_SCAN: keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r && !push;
    if (accept && keep) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cmd_r.op       <= in_mode;
      cmd_r.id       <= in_timer_id;
      cmd_r.in_range <= (32'(in_timer_id) < SLOTS);
      cmd_r.period   <= in_period;
      cmd_r.now      <= in_now_time;
    end
  end

endmodule

@@ rtl/ptset_cmd_fifo.sv @@
// Short request queue between the front end and the slot engine.
// Depends on ptset_pkg for the request type and depth.
`timescale 1ns / 1ps

module ptset_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ptset_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output ptset_pkg::cmd_t   pop_cmd,
  output ptset_pkg::qstat_t q_stat
);

  localparam int QD  = ptset_pkg::QDEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;

  ptset_pkg::cmd_t  mem_r [QD];
  logic [QPW-1:0]   wptr_r, wptr_nxt;
  logic [QPW-1:0]   rptr_r, rptr_nxt;
  logic [QPW:0]     cnt_r, cnt_nxt;

  assign pop_cmd      = mem_r[rptr_r];
  assign q_stat.full  = (cnt_r == (QPW+1)'(QD));
  assign q_stat.empty = (cnt_r == '0);

  function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
    return (p == QPW'(QD-1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_nxt = push ? bump(wptr_r) : wptr_r;
    rptr_nxt = pop  ? bump(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_cmd;
  end

endmodule

@@ rtl/ptset_exec.sv @@
// Slot engine: applies a request, walks the slots one per cycle to
// reschedule and find the earliest expiry, then emits results.
// Depends on ptset_pkg; drains ptset_cmd_fifo and drives the out_ channel.
`timescale 1ns / 1ps

module ptset_exec #(
  parameter int NUM_TIMERS = ptset_pkg::NUM_TIMERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptset_pkg::cmd_t           q_cmd,
  input  ptset_pkg::qstat_t         q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [3:0]                out_slot,
  output logic                      out_found,
  output logic [ptset_pkg::TW-1:0]  out_next_shot,
  output logic                      out_last
);

  localparam int SLOTS = (NUM_TIMERS < ptset_pkg::SLOT_CAP) ? NUM_TIMERS : ptset_pkg::SLOT_CAP;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW    = ptset_pkg::TW;
  localparam int PW    = ptset_pkg::PW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_FIRE  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [SLOTS-1:0] slot_active_r;
  logic [PW-1:0]    slot_period_r [SLOTS];
  logic [TW-1:0]    slot_expiry_r [SLOTS];

  logic [2:0]       state_r, state_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SLOTS-1:0] fired_r, fired_nxt;
  logic [TW-1:0]    min_r, min_nxt;
  logic             any_r, any_nxt;
  logic [TW-1:0]    nxt_r;
  logic             found_r;
  ptset_pkg::cmd_t  cmd_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [3:0]       out_slot_r;
  logic             out_found_r;
  logic [TW-1:0]    out_next_shot_r;
  logic             out_last_r;

  logic             can_load, load;
  logic [1:0]       ld_kind;
  logic [3:0]       ld_slot;
  logic             ld_found, ld_last;

  logic             rd_act, fire, at_end;
  logic [PW-1:0]    rd_per;
  logic [TW-1:0]    rd_exp, resched, cand;
  logic [SW-1:0]    qid;

  assign qid      = q_cmd.id[SW-1:0];
  assign rd_act   = slot_active_r[idx_r];
  assign rd_per   = slot_period_r[idx_r];
  assign rd_exp   = slot_expiry_r[idx_r];
  assign fire     = (cmd_r.op == ptset_pkg::MODE_SCAN) && rd_act && (rd_exp <= cmd_r.now);
  assign resched  = ptset_pkg::sat_add(cmd_r.now, rd_per);
  assign cand     = fire ? resched : rd_exp;
  assign at_end   = (idx_r == SW'(SLOTS-1));
  assign can_load = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fired_nxt = fired_r;
    min_nxt   = min_r;
    any_nxt   = any_r;
    load      = 1'b0;
    ld_kind   = ptset_pkg::KIND_DONE;
    ld_slot   = '0;
    ld_found  = 1'b0;
    ld_last   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          idx_nxt   = '0;
          fired_nxt = '0;
          min_nxt   = ptset_pkg::TIME_MAX;
          any_nxt   = 1'b0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (fire) fired_nxt[idx_r] = 1'b1;
        if (rd_act && cand < min_r) min_nxt = cand;
        any_nxt = any_r || rd_act;
        if (at_end) begin
          state_nxt = S_DIFF;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIFF: begin
        idx_nxt   = '0;
        state_nxt = (cmd_r.op == ptset_pkg::MODE_SCAN) ? S_FIRE : S_FINAL;
      end
      S_FIRE: begin
        // skip quiet slots; hold on a fired slot until the output frees up
        if (!fired_r[idx_r] || can_load) begin
          load    = fired_r[idx_r];
          ld_kind = ptset_pkg::KIND_FIRED;
          ld_slot = 4'(idx_r);
          if (at_end) begin
            state_nxt = S_FINAL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (can_load) begin
          load     = 1'b1;
          ld_last  = 1'b1;
          ld_found = found_r;
          unique case (cmd_r.op)
            ptset_pkg::MODE_ADD:    ld_kind = ptset_pkg::KIND_ADD;
            ptset_pkg::MODE_REMOVE: ld_kind = ptset_pkg::KIND_REMOVE;
            default:                ld_kind = ptset_pkg::KIND_DONE;
          endcase
          ld_slot   = (cmd_r.op == ptset_pkg::MODE_SCAN) ? 4'd0 : cmd_r.id;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      slot_active_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop && q_cmd.in_range) begin
        if (q_cmd.op == ptset_pkg::MODE_ADD)    slot_active_r[qid] <= 1'b1;
        if (q_cmd.op == ptset_pkg::MODE_REMOVE) slot_active_r[qid] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    fired_r <= fired_nxt;
    min_r   <= min_nxt;
    any_r   <= any_nxt;
    if (pop) begin
      cmd_r   <= q_cmd;
      found_r <= (q_cmd.op == ptset_pkg::MODE_REMOVE) && q_cmd.in_range && slot_active_r[qid];
    end
    if (state_r == S_DIFF) begin
      if (!any_r) begin
        nxt_r <= ptset_pkg::TIME_MAX;
      end else if (min_r > cmd_r.now) begin
        nxt_r <= min_r - cmd_r.now;
      end else begin
        nxt_r <= '0;
      end
    end
    if (load) begin
      out_kind_r      <= ld_kind;
      out_slot_r      <= ld_slot;
      out_found_r     <= ld_found;
      out_next_shot_r <= nxt_r;
      out_last_r      <= ld_last;
    end
  end

  // slot storage: armed by add, rescheduled during a scan walk
  always_ff @(posedge clk) begin
    if (pop && q_cmd.in_range && q_cmd.op == ptset_pkg::MODE_ADD) begin
      slot_period_r[qid] <= q_cmd.period;
      slot_expiry_r[qid] <= ptset_pkg::sat_add(q_cmd.now, q_cmd.period);
    end else if (state_r == S_WALK && fire) begin
      slot_expiry_r[idx_r] <= resched;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_slot      = out_slot_r;
  assign out_found     = out_found_r;
  assign out_next_shot = out_next_shot_r;
  assign out_last      = out_last_r;

endmodule

@@ rtl/periodic_timer_set.sv @@
// Periodic timer set: up to sixteen slots, each with a period and an expiry.
//
// Input channel (in_valid / in_stall): one request per item. Mode add arms
// slot in_timer_id with in_period, remove frees it, scan fires every due
// slot at in_now_time. Mode 3 is taken and dropped without a result.
// Result channel (out_valid / out_stall): add and remove give one result;
// a scan gives one result per fired slot, in slot order, then a closing
// result. out_last marks the final result of each request, and every
// result carries the time to the earliest expiry after the update.
// Order of work: with S = min(NUM_TIMERS, 16), the slot engine takes one
// request at a time; it walks all S slots, then for a scan makes a second
// pass that sends each fired slot, then it sends the final result.
// The walk reads the slot file through a single index, one slot per cycle,
// and never stalls. A two-entry request queue lets the front end
// keep taking requests while the engine works or the receiver stalls.
// A stalled result holds in the output register and the engine waits.
// Reset (rst_n, synchronous) clears all slots to inactive at once and
// empties the queue; no clearing pass follows.
// Depends on ptset_pkg, ptset_front, ptset_cmd_fifo, ptset_exec.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_timer_set #(
  parameter int NUM_TIMERS = ptset_pkg::NUM_TIMERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_mode,
  input  logic [3:0]                in_timer_id,
  input  logic [ptset_pkg::PW-1:0]  in_period,
  input  logic [ptset_pkg::TW-1:0]  in_now_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [3:0]                out_slot,
  output logic                      out_found,
  output logic [ptset_pkg::TW-1:0]  out_next_shot,
  output logic                      out_last
);

  logic              push, pop;
  ptset_pkg::cmd_t   push_cmd, pop_cmd;
  ptset_pkg::qstat_t q_stat;

  ptset_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_timer_id (in_timer_id),
    .in_period   (in_period),
    .in_now_time (in_now_time),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_stat      (q_stat)
  );

  ptset_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  ptset_exec #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (pop_cmd),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_slot      (out_slot),
    .out_found     (out_found),
    .out_next_shot (out_next_shot),
    .out_last      (out_last)
  );

  `PTS_ASSERT_IMPLY(a_single_is_last, clk, rst_n, out_valid && (out_kind == ptset_pkg::KIND_ADD || out_kind == ptset_pkg::KIND_REMOVE), out_last)
  `PTS_ASSERT_IMPLY(a_fired_not_last, clk, rst_n, out_valid && out_kind == ptset_pkg::KIND_FIRED, !out_last)
  `PTS_ASSERT_IMPLY(a_found_on_remove, clk, rst_n, out_valid && out_kind != ptset_pkg::KIND_REMOVE, !out_found)
  `PTS_ASSERT_NEVER(a_queue_flags, clk, rst_n, q_stat.full && q_stat.empty)

endmodule
